// ===== hw/rtl/register_mapped_alu_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the register-mapped ALU
// Shared clocked property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef REGISTER_MAPPED_ALU_ASSERT_SVH
`define REGISTER_MAPPED_ALU_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RMA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("register_mapped_alu assertion failed");

// Next-cycle implication, disabled during reset.
`define RMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("register_mapped_alu assertion failed");

`endif

// ===== hw/rtl/rma_pkg.sv =====
// ----------------------------------------------------------------------------
// Register-mapped ALU package
// Command, status, address and op codes shared by the block and its checker.
// ----------------------------------------------------------------------------
package rma_pkg;

   // Request commands.
   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   // Response status codes.
   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_GENERIC  = 2'd1;
   localparam logic [1:0] STS_ADDRESS  = 2'd2;
   localparam logic [1:0] STS_COMMAND  = 2'd3;

   // Register addresses.
   localparam logic [15:0] ADDR_OPERANDS = 16'h0000;
   localparam logic [15:0] ADDR_RESULT   = 16'h0002;
   localparam logic [15:0] ADDR_CONTROL  = 16'h0004;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SINGLE_LAT = 2'd0;
   localparam logic [1:0] CSR_MUL_LAT    = 2'd1;
   localparam logic [1:0] CSR_BUS_LAT    = 2'd2;

   // Low three bits of the op field.
   localparam logic [2:0] OP_ADD = 3'b001;
   localparam logic [2:0] OP_AND = 3'b010;
   localparam logic [2:0] OP_XOR = 3'b011;

   // Bit of the op field that selects multiply.
   localparam int OP_MUL_BIT = 2;

endpackage

// ===== hw/rtl/register_mapped_alu.sv =====
// ----------------------------------------------------------------------------
// Register-mapped 8-bit ALU
// Bus-style register file with an add/and/xor/multiply unit and tick timing.
// ----------------------------------------------------------------------------
// Usage:
// - The request channel (req_*) carries reads, writes, time ticks and
//   unsupported commands; each request yields exactly one response on the
//   rsp_* channel with read data and a status code, in request order.
// - The csr_* channel sets the single-op, multiply and bus latencies (in
//   ticks); always ready. Write it only while the block is idle (unchecked).
// - A request is decoded, merged into the registers and the ALU result is
//   computed in the cycle it is accepted, and its response is registered.
//   One request per cycle is sustained while req_ready is high; the rate
//   is set by the single register update path, with one 8x8 multiplier.
// - A two-entry output stage (response register plus skid register) keeps
//   req_ready high while one response waits; req_ready drops only once both
//   entries are full, and rises again when the receiver takes a response.
// - Reset clears all architectural registers, flags and the countdown,
//   and restores the latencies to 1, 3 and 1 ticks.
// ----------------------------------------------------------------------------
module register_mapped_alu (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [15:0] req_address,
   input  logic [31:0] req_write_data,
   input  logic [3:0]  req_byte_enable,
   input  logic [2:0]  req_data_length,
   input  logic [7:0]  req_lead_ticks,
   // Response channel.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic [1:0]  rsp_status,
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   // Configuration registers.
   logic [15:0] single_lat_ff;
   logic [15:0] mul_lat_ff;
   logic [7:0]  bus_lat_ff;

   // Architectural state.
   logic [7:0]  operand_a_ff, operand_a_in;
   logic [7:0]  operand_b_ff, operand_b_in;
   logic [4:0]  op_field_ff, op_field_in;
   logic        start_ff, start_in;
   logic [8:0]  spare_ff, spare_in;
   logic        done_ff, done_in;
   logic [15:0] result_ff, result_in;
   logic        busy_ff, busy_in;
   logic [15:0] pending_ff, pending_in;
   logic [15:0] ticks_left_ff, ticks_left_in;

   // Output stage.
   logic        out_valid_ff;
   logic [31:0] out_data_ff;
   logic [1:0]  out_status_ff;
   logic        skid_valid_ff;
   logic [31:0] skid_data_ff;
   logic [1:0]  skid_status_ff;

   // Per-request combinational results.
   logic        accept;
   logic        out_free;
   logic [31:0] new_data;
   logic [1:0]  new_status;
   logic [8:0]  advance;
   logic [31:0] len_mask;
   logic [31:0] wdata_masked;
   logic [15:0] operands_word;
   logic [15:0] control_word;
   logic [15:0] merged;
   logic [2:0]  op3;
   logic [15:0] alu_value;
   logic [15:0] product;

   // Byte-enabled merge of a 16-bit register word.
   function automatic logic [15:0] merge16(input logic [15:0] old_word,
                                           input logic [15:0] new_word,
                                           input logic [1:0]  enables);
      logic [15:0] word;
      word = old_word;
      if (enables[0]) begin
         word[7:0] = new_word[7:0];
      end
      if (enables[1]) begin
         word[15:8] = new_word[15:8];
      end
      return word;
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = !skid_valid_ff;
   assign csr_ready = 1'b1;
   assign out_free  = !out_valid_ff || rsp_ready;

   assign rsp_valid     = out_valid_ff;
   assign rsp_read_data = out_data_ff;
   assign rsp_status    = out_status_ff;

   // The multiplier works on the stored operands.
   assign product = {8'd0, operand_a_ff} * {8'd0, operand_b_ff};

   // Next state and response for the accepted request.
   always_comb begin
      operand_a_in  = operand_a_ff;
      operand_b_in  = operand_b_ff;
      op_field_in   = op_field_ff;
      start_in      = start_ff;
      spare_in      = spare_ff;
      done_in       = done_ff;
      result_in     = result_ff;
      busy_in       = busy_ff;
      pending_in    = pending_ff;
      ticks_left_in = ticks_left_ff;
      new_data      = 32'd0;
      new_status    = rma_pkg::STS_OK;
      operands_word = 16'd0;
      control_word  = 16'd0;
      merged        = 16'd0;
      op3           = 3'd0;
      alu_value     = 16'd0;

      // Length mask; lengths above four act as four.
      unique case (req_data_length)
         3'd1:    len_mask = 32'h0000_00FF;
         3'd2:    len_mask = 32'h0000_FFFF;
         3'd3:    len_mask = 32'h00FF_FFFF;
         default: len_mask = 32'hFFFF_FFFF;
      endcase
      wdata_masked = req_write_data & len_mask;

      // Time advanced by this request.
      if (req_command == rma_pkg::CMD_TICK) begin
         advance = 9'd1;
      end else begin
         advance = {1'b0, req_lead_ticks} + {1'b0, bus_lat_ff};
      end

      if (accept && (req_command == rma_pkg::CMD_TICK || req_data_length != 3'd0)) begin
         // Countdown; the operation completes when the advance covers it.
         if (busy_ff) begin
            if (ticks_left_ff <= {7'd0, advance}) begin
               result_in     = pending_ff;
               done_in       = 1'b1;
               busy_in       = 1'b0;
               ticks_left_in = 16'd0;
            end else begin
               ticks_left_in = ticks_left_ff - {7'd0, advance};
            end
         end

         operands_word = {operand_b_ff, operand_a_ff};
         control_word  = {spare_ff, done_in, start_ff, op_field_ff};

         // Register access after time has advanced.
         unique case (req_command)
            rma_pkg::CMD_READ: begin
               if (req_address == rma_pkg::ADDR_OPERANDS) begin
                  new_data = {16'd0, operands_word} & len_mask;
               end else if (req_address == rma_pkg::ADDR_RESULT) begin
                  new_data = {16'd0, result_in} & len_mask;
               end else if (req_address == rma_pkg::ADDR_CONTROL) begin
                  new_data = {16'd0, control_word} & len_mask;
               end else begin
                  new_status = rma_pkg::STS_ADDRESS;
               end
            end
            rma_pkg::CMD_WRITE: begin
               if (req_address == rma_pkg::ADDR_OPERANDS) begin
                  merged       = merge16(operands_word, wdata_masked[15:0],
                                         req_byte_enable[1:0]);
                  operand_a_in = merged[7:0];
                  operand_b_in = merged[15:8];
               end else if (req_address == rma_pkg::ADDR_CONTROL) begin
                  merged      = merge16(control_word, wdata_masked[15:0],
                                        req_byte_enable[1:0]);
                  op_field_in = merged[4:0];
                  start_in    = merged[5];
                  spare_in    = merged[15:7];
                  op3         = merged[2:0];
                  // Start a new operation; it replaces any pending one.
                  if (merged[5] && op3 != 3'd0) begin
                     priority if (op3[rma_pkg::OP_MUL_BIT]) begin
                        alu_value = product;
                     end else if (op3 == rma_pkg::OP_ADD) begin
                        alu_value = {8'd0, operand_a_ff} + {8'd0, operand_b_ff};
                     end else if (op3 == rma_pkg::OP_AND) begin
                        alu_value = {8'd0, operand_a_ff & operand_b_ff};
                     end else begin
                        alu_value = {8'd0, operand_a_ff ^ operand_b_ff};
                     end
                     busy_in    = 1'b1;
                     done_in    = 1'b0;
                     pending_in = alu_value;
                     ticks_left_in = op3[rma_pkg::OP_MUL_BIT] ? mul_lat_ff
                                                              : single_lat_ff;
                  end
               end else if (req_address != rma_pkg::ADDR_RESULT) begin
                  new_status = rma_pkg::STS_ADDRESS;
               end
            end
            rma_pkg::CMD_TICK: begin
               new_status = rma_pkg::STS_OK;
            end
            default: begin
               new_status = rma_pkg::STS_COMMAND;
            end
         endcase
      end else begin
         // Zero length: error response, nothing changes.
         new_status = rma_pkg::STS_GENERIC;
      end
   end

   // Configuration and architectural registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         single_lat_ff <= 16'd1;
         mul_lat_ff    <= 16'd3;
         bus_lat_ff    <= 8'd1;
         operand_a_ff  <= 8'd0;
         operand_b_ff  <= 8'd0;
         op_field_ff   <= 5'd0;
         start_ff      <= 1'b0;
         spare_ff      <= 9'd0;
         done_ff       <= 1'b0;
         result_ff     <= 16'd0;
         busy_ff       <= 1'b0;
         pending_ff    <= 16'd0;
         ticks_left_ff <= 16'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               rma_pkg::CSR_SINGLE_LAT: single_lat_ff <= csr_write_data;
               rma_pkg::CSR_MUL_LAT:    mul_lat_ff    <= csr_write_data;
               rma_pkg::CSR_BUS_LAT:    bus_lat_ff    <= csr_write_data[7:0];
               default: begin
               end
            endcase
         end
         operand_a_ff  <= operand_a_in;
         operand_b_ff  <= operand_b_in;
         op_field_ff   <= op_field_in;
         start_ff      <= start_in;
         spare_ff      <= spare_in;
         done_ff       <= done_in;
         result_ff     <= result_in;
         busy_ff       <= busy_in;
         pending_ff    <= pending_in;
         ticks_left_ff <= ticks_left_in;
      end
   end

   // Response register with a skid entry behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            out_data_ff   <= skid_data_ff;
            out_status_ff <= skid_status_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= accept;
            out_data_ff   <= new_data;
            out_status_ff <= new_status;
         end
      end else if (accept) begin
         skid_valid_ff  <= 1'b1;
         skid_data_ff   <= new_data;
         skid_status_ff <= new_status;
      end
   end

endmodule

// ===== hw/rtl/rma_checker.sv =====
// ----------------------------------------------------------------------------
// Register-mapped ALU checker
// Port-level properties of the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "register_mapped_alu_assert.svh"

module rma_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_read_data,
   input logic [1:0]  rsp_status
);

   // A stalled response holds its payload.
   `RMA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_read_data) && $stable(rsp_status))

   // Failed requests return no data.
   `RMA_ASSERT_NOW(a_err_no_data, clock, reset,
      rsp_valid && rsp_status != rma_pkg::STS_OK, rsp_read_data == 32'd0)

   // All registers are 16 bits wide, so the upper half reads as zero.
   `RMA_ASSERT_NOW(a_upper_zero, clock, reset, rsp_valid, rsp_read_data[31:16] == 16'd0)

   // A request accepted into a free output stage responds next cycle.
   `RMA_ASSERT_NEXT(a_rsp_latency, clock, reset,
      req_valid && req_ready && (!rsp_valid || rsp_ready), rsp_valid)

endmodule

bind register_mapped_alu rma_checker u_rma_checker (.*);
